// ===== hw/rtl/lmq_pkg.sv =====
// ----------------------------------------------------------------------------
// lmq_pkg
// Shared types and constants of the Lloyd-Max quantizer design unit: the
// command and result payloads, the sequencer states and the accumulator
// control group.
// ----------------------------------------------------------------------------
`default_nettype none

package lmq_pkg;

    // Fixed field widths
    localparam int SYM_W      = 6;
    localparam int WEIGHT_W   = 16;
    localparam int SUM_W      = 38;
    localparam int PASS_W     = 10;
    localparam int CNT_W      = 7;
    localparam int MAX_STATES = 64;

    // Command modes
    localparam logic [1:0] MODE_PROB   = 2'd0;
    localparam logic [1:0] MODE_DIST   = 2'd1;
    localparam logic [1:0] MODE_DESIGN = 2'd2;
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    // Register indexes (paddr[3:2])
    localparam logic [1:0] REG_STATES = 2'd0;
    localparam logic [1:0] REG_ALPHA  = 2'd1;
    localparam logic [1:0] REG_LIMIT  = 2'd2;

    typedef struct packed {
        logic [1:0]          mode;
        logic [SYM_W-1:0]    symbol;
        logic [SYM_W-1:0]    point;
        logic [WEIGHT_W-1:0] weight;
    } t_item;

    typedef struct packed {
        logic [SYM_W-1:0]  source_symbol;
        logic [SYM_W-1:0]  mapped_point;
        logic              last_of_run;
        logic [SUM_W-1:0]  total_distortion;
        logic [PASS_W-1:0] passes_used;
    } t_result;

    // Accumulator control from the sequencer
    typedef struct packed {
        logic clear;
        logic mul;
        logic acc;
    } t_mac_ctl;

    typedef enum logic [5:0] {
        ST_IDLE,
        ST_SCAN_RD,
        ST_SCAN_CHK,
        ST_SEED_DIV,
        ST_SEED_RD,
        ST_SEED_WR,
        ST_PASS_CHK,
        ST_RG_LO,
        ST_RG_HI,
        ST_RG_SET,
        ST_TM_RD,
        ST_TM_MUL,
        ST_TM_ACC,
        ST_PT_CMP,
        ST_RG_END,
        ST_BD_INIT,
        ST_BD_P0,
        ST_BD_P1,
        ST_BD_LOOP,
        ST_BD_RA,
        ST_BD_RB,
        ST_MAP_CLR,
        ST_FL_B0,
        ST_FL_B1,
        ST_FL_M,
        ST_FL_WR,
        ST_FH_B,
        ST_FH_BS,
        ST_FH_BP,
        ST_FH_M,
        ST_FH_WR,
        ST_OUT_RD,
        ST_OUT_EM
    } t_state;

endpackage

`default_nettype wire

// ===== hw/rtl/lloyd_max_quantizer_design_unit.sv =====
// ----------------------------------------------------------------------------
// lloyd_max_quantizer_design_unit
// Lloyd-Max scalar quantizer design over a discrete alphabet.
//
// Usage: load probabilities (mode 0) and distortion entries (mode 1) with a
// start pulse each; a load is written from idle and busy stays low. A mode 2
// command raises busy and runs the design: a mass scan, bound seeding,
// Lloyd-Max passes until nothing changes or iteration_limit is reached, then
// one result per symbol 0..N-1, each on o_result for one cycle with o_strobe.
// The receiver cannot stall; each result passes a read and an emit state.
// A design scans the alphabet for mass, seeds the S+1 bounds by repeated
// subtraction, and in each pass walks every region of L symbols through L^2
// products in the shared multiply-accumulate unit (read, multiply and
// accumulate states per product) before the bound move; it then clears all 64
// map entries, forms the map and distortion sum, and sends the results. The
// shared unit sets the pace. busy drops with the last result. Configuration
// registers sit on the APB port (0x0 states, 0x4 alphabet, 0x8 iteration
// limit) and reset to 1, 64 and 100. Reset returns the sequencer to idle;
// tables hold nothing defined until loaded.
// ----------------------------------------------------------------------------
`default_nettype none

module lloyd_max_quantizer_design_unit
    import lmq_pkg::*;
#(
    parameter int ALPHABET_DEPTH = 64
)
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    input  wire logic        start,
    output logic             busy,
    input  wire t_item       i_item,
    output logic             o_strobe,
    output t_result          o_result
);

    localparam int LIM = (ALPHABET_DEPTH < 64) ? ALPHABET_DEPTH : 64;
    localparam int PAW = (LIM > 1) ? $clog2(LIM) : 1;
    localparam int DAW = $clog2(LIM * LIM);

    function automatic logic [DAW-1:0] daddr(input logic [SYM_W-1:0] sym,
                                             input logic [SYM_W-1:0] pt);
        daddr = DAW'(int'(sym) * LIM + int'(pt));
    endfunction

    // Configuration registers
    logic [CNT_W-1:0]  r_cfg_states;
    logic [CNT_W-1:0]  r_cfg_alpha;
    logic [PASS_W-1:0] r_cfg_limit;
    logic              cfg_we;

    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_states <= CNT_W'(1);
            r_cfg_alpha  <= CNT_W'(64);
            r_cfg_limit  <= PASS_W'(100);
        end else if (cfg_we) begin
            unique case (paddr[3:2])
                REG_STATES: r_cfg_states <= pwdata[CNT_W-1:0];
                REG_ALPHA:  r_cfg_alpha  <= pwdata[CNT_W-1:0];
                REG_LIMIT:  r_cfg_limit  <= pwdata[PASS_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_STATES: prdata = 32'(r_cfg_states);
            REG_ALPHA:  prdata = 32'(r_cfg_alpha);
            REG_LIMIT:  prdata = 32'(r_cfg_limit);
            default:    prdata = '0;
        endcase
    end

    // Memories
    logic [WEIGHT_W-1:0] m_prob [LIM];
    logic [WEIGHT_W-1:0] m_dist [LIM*LIM];
    logic [SYM_W-1:0]    m_mass [MAX_STATES];
    logic [CNT_W-1:0]    m_bnd  [MAX_STATES+1];
    logic [SYM_W-1:0]    m_pt   [MAX_STATES];
    logic [SYM_W:0]      m_map  [MAX_STATES];

    logic [WEIGHT_W-1:0] r_prob_rd, r_dist_rd;
    logic [SYM_W-1:0]    r_mass_rd, r_pt_rd;
    logic [CNT_W-1:0]    r_bnd_rd;
    logic [SYM_W:0]      r_map_rd;

    logic                prob_we, dist_we, mass_we, bnd_we, pt_we, map_we;
    logic [PAW-1:0]      prob_waddr, prob_raddr;
    logic [DAW-1:0]      dist_waddr, dist_raddr;
    logic [SYM_W-1:0]    mass_waddr, mass_raddr, mass_wdata;
    logic [CNT_W-1:0]    bnd_waddr, bnd_raddr, bnd_wdata;
    logic [SYM_W-1:0]    pt_waddr, pt_raddr, pt_wdata;
    logic [SYM_W-1:0]    map_waddr, map_raddr;
    logic [SYM_W:0]      map_wdata;

    always_ff @(posedge i_clk) begin
        if (prob_we) begin
            m_prob[prob_waddr] <= i_item.weight;
        end
        r_prob_rd <= m_prob[prob_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (dist_we) begin
            m_dist[dist_waddr] <= i_item.weight;
        end
        r_dist_rd <= m_dist[dist_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (mass_we) begin
            m_mass[mass_waddr] <= mass_wdata;
        end
        r_mass_rd <= m_mass[mass_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (bnd_we) begin
            m_bnd[bnd_waddr] <= bnd_wdata;
        end
        r_bnd_rd <= m_bnd[bnd_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (pt_we) begin
            m_pt[pt_waddr] <= pt_wdata;
        end
        r_pt_rd <= m_pt[pt_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (map_we) begin
            m_map[map_waddr] <= map_wdata;
        end
        r_map_rd <= m_map[map_raddr];
    end

    // Shared multiply-accumulate unit
    t_mac_ctl         mac_ctl;
    logic [SUM_W-1:0] mac_acc;

    lmq_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (mac_ctl),
        .i_prob  (r_prob_rd),
        .i_dist  (r_dist_rd),
        .o_acc   (mac_acc)
    );

    // Sequencer registers
    t_state            r_state, n_state;
    logic [CNT_W-1:0]  r_s, n_s, r_n, n_n;
    logic [PASS_W-1:0] r_lim, n_lim, r_pc, n_pc;
    logic [CNT_W-1:0]  r_i, n_i, r_j, n_j, r_r, n_r, r_k, n_k;
    logic [CNT_W-1:0]  r_mc, n_mc, r_q, n_q, r_prev, n_prev;
    logic [CNT_W:0]    r_rem, n_rem;
    logic [SYM_W-1:0]  r_last, n_last;
    logic [CNT_W-1:0]  r_lo, n_lo, r_hi, n_hi, r_bndv, n_bndv;
    logic [SYM_W-1:0]  r_cur, n_cur, r_best, n_best, r_pa, n_pa, r_pb, n_pb;
    logic [SUM_W-1:0]  r_best_v, n_best_v;
    logic [WEIGHT_W-1:0] r_here, n_here;
    logic              r_first, n_first, r_changed, n_changed, r_map_ph, n_map_ph;
    logic [SYM_W:0]    r_fill, n_fill;
    logic              r_strobe, n_strobe;
    t_result           r_out, n_out;

    logic              accept, simple;
    logic [CNT_W-1:0]  s_cl, n_cl, seed_val, nr;
    logic [CNT_W:0]    mid_sum;
    logic [CNT_W:0]    mid_m1;

    assign busy     = (r_state != ST_IDLE);
    assign accept   = start && !busy;
    assign o_strobe = r_strobe;
    assign o_result = r_out;
    assign simple   = (r_mc == '0) || (r_s == CNT_W'(1));

    // Clamp the configured sizes
    always_comb begin
        if (r_cfg_states == '0) begin
            s_cl = CNT_W'(1);
        end else if (r_cfg_states > CNT_W'(MAX_STATES)) begin
            s_cl = CNT_W'(MAX_STATES);
        end else begin
            s_cl = r_cfg_states;
        end
        if (r_cfg_alpha < CNT_W'(2)) begin
            n_cl = CNT_W'(2);
        end else if (r_cfg_alpha > CNT_W'(LIM)) begin
            n_cl = CNT_W'(LIM);
        end else begin
            n_cl = r_cfg_alpha;
        end
    end

    // Seed bound value and midpoint of the region it closes
    always_comb begin
        if (simple) begin
            seed_val = (r_j == r_s) ? r_n : '0;
        end else begin
            seed_val = (r_j == r_s) ? (CNT_W'(r_last) + CNT_W'(1)) : CNT_W'(r_mass_rd);
        end
        mid_sum = {1'b0, r_prev} + {1'b0, seed_val};
        mid_m1  = mid_sum - (CNT_W+1)'(1);
        nr      = r_r + CNT_W'(1);
    end

    // Next state and memory controls
    always_comb begin
        n_state   = r_state;
        n_s       = r_s;
        n_n       = r_n;
        n_lim     = r_lim;
        n_pc      = r_pc;
        n_i       = r_i;
        n_j       = r_j;
        n_r       = r_r;
        n_k       = r_k;
        n_mc      = r_mc;
        n_q       = r_q;
        n_prev    = r_prev;
        n_rem     = r_rem;
        n_last    = r_last;
        n_lo      = r_lo;
        n_hi      = r_hi;
        n_bndv    = r_bndv;
        n_cur     = r_cur;
        n_best    = r_best;
        n_pa      = r_pa;
        n_pb      = r_pb;
        n_best_v  = r_best_v;
        n_here    = r_here;
        n_first   = r_first;
        n_changed = r_changed;
        n_map_ph  = r_map_ph;
        n_fill    = r_fill;
        n_strobe  = 1'b0;
        n_out     = r_out;

        mac_ctl    = '0;
        prob_we    = 1'b0;
        dist_we    = 1'b0;
        mass_we    = 1'b0;
        bnd_we     = 1'b0;
        pt_we      = 1'b0;
        map_we     = 1'b0;
        prob_waddr = i_item.symbol[PAW-1:0];
        dist_waddr = daddr(i_item.symbol, i_item.point);
        prob_raddr = r_i[PAW-1:0];
        dist_raddr = daddr(r_i[SYM_W-1:0], r_r[SYM_W-1:0]);
        mass_waddr = r_mc[SYM_W-1:0];
        mass_wdata = r_i[SYM_W-1:0];
        mass_raddr = r_q[SYM_W-1:0];
        bnd_waddr  = r_j;
        bnd_wdata  = seed_val;
        bnd_raddr  = r_j;
        pt_waddr   = r_j[SYM_W-1:0];
        pt_wdata   = r_best;
        pt_raddr   = r_j[SYM_W-1:0];
        map_waddr  = r_i[SYM_W-1:0];
        map_wdata  = {1'b1, r_cur};
        map_raddr  = r_k[SYM_W-1:0];

        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    unique case (i_item.mode)
                        MODE_PROB: begin
                            prob_we = (int'(i_item.symbol) < ALPHABET_DEPTH);
                        end
                        MODE_DIST: begin
                            dist_we = (int'(i_item.symbol) < ALPHABET_DEPTH) &&
                                      (int'(i_item.point) < ALPHABET_DEPTH);
                        end
                        MODE_DESIGN: begin
                            n_s     = s_cl;
                            n_n     = n_cl;
                            n_lim   = r_cfg_limit;
                            n_i     = '0;
                            n_mc    = '0;
                            n_last  = '0;
                            n_state = ST_SCAN_RD;
                        end
                        default: ;
                    endcase
                end
            end

            // Collect the symbols that carry mass
            ST_SCAN_RD: begin
                n_state = ST_SCAN_CHK;
            end
            ST_SCAN_CHK: begin
                if (r_prob_rd != '0) begin
                    mass_we = 1'b1;
                    n_mc    = r_mc + CNT_W'(1);
                    n_last  = r_i[SYM_W-1:0];
                end
                if (r_i + CNT_W'(1) == r_n) begin
                    n_j     = '0;
                    n_q     = '0;
                    n_rem   = '0;
                    n_prev  = '0;
                    n_state = ST_SEED_DIV;
                end else begin
                    n_i     = r_i + CNT_W'(1);
                    n_state = ST_SCAN_RD;
                end
            end

            // Step j*mc/s one subtract at a time
            ST_SEED_DIV: begin
                if (!simple && (r_rem >= {1'b0, r_s})) begin
                    n_rem = r_rem - {1'b0, r_s};
                    n_q   = r_q + CNT_W'(1);
                end else begin
                    n_state = ST_SEED_RD;
                end
            end
            ST_SEED_RD: begin
                n_state = ST_SEED_WR;
            end
            ST_SEED_WR: begin
                bnd_we = 1'b1;
                if (r_j != '0) begin
                    pt_we    = 1'b1;
                    pt_waddr = 6'(r_j - CNT_W'(1));
                    pt_wdata = (mid_sum == '0) ? '0 : mid_m1[SYM_W:1];
                end
                n_prev = seed_val;
                if (r_j == r_s) begin
                    n_changed = 1'b1;
                    n_pc      = '0;
                    n_state   = ST_PASS_CHK;
                end else begin
                    n_j     = r_j + CNT_W'(1);
                    n_rem   = r_rem + {1'b0, r_mc};
                    n_state = ST_SEED_DIV;
                end
            end

            // Decide on another pass
            ST_PASS_CHK: begin
                if (r_changed && (r_pc < r_lim)) begin
                    n_pc      = r_pc + PASS_W'(1);
                    n_changed = 1'b0;
                    n_j       = '0;
                    n_map_ph  = 1'b0;
                    n_state   = ST_RG_LO;
                end else begin
                    n_k     = '0;
                    n_state = ST_MAP_CLR;
                end
            end

            // Region walk, shared by point choice and final mapping
            ST_RG_LO: begin
                n_state = ST_RG_HI;
            end
            ST_RG_HI: begin
                n_lo      = r_bnd_rd;
                bnd_raddr = r_j + CNT_W'(1);
                n_state   = ST_RG_SET;
            end
            ST_RG_SET: begin
                n_hi  = r_bnd_rd;
                n_cur = r_pt_rd;
                n_i   = r_lo;
                if (r_map_ph) begin
                    n_r = CNT_W'(r_pt_rd);
                end else begin
                    n_best      = r_lo[SYM_W-1:0];
                    n_first     = 1'b1;
                    n_r         = r_lo;
                    mac_ctl.clear = 1'b1;
                end
                n_state = (r_lo >= r_bnd_rd) ? ST_RG_END : ST_TM_RD;
            end
            ST_TM_RD: begin
                map_we  = r_map_ph;
                n_state = ST_TM_MUL;
            end
            ST_TM_MUL: begin
                mac_ctl.mul = 1'b1;
                n_state     = ST_TM_ACC;
            end
            ST_TM_ACC: begin
                mac_ctl.acc = 1'b1;
                if (r_i + CNT_W'(1) == r_hi) begin
                    n_state = r_map_ph ? ST_RG_END : ST_PT_CMP;
                end else begin
                    n_i     = r_i + CNT_W'(1);
                    n_state = ST_TM_RD;
                end
            end
            ST_PT_CMP: begin
                if (r_first || (mac_acc < r_best_v)) begin
                    n_best   = r_r[SYM_W-1:0];
                    n_best_v = mac_acc;
                    n_first  = 1'b0;
                end
                if (nr == r_hi) begin
                    n_state = ST_RG_END;
                end else begin
                    n_r           = nr;
                    n_i           = r_lo;
                    mac_ctl.clear = 1'b1;
                    n_state       = ST_TM_RD;
                end
            end
            ST_RG_END: begin
                if (!r_map_ph && (r_best != r_cur)) begin
                    pt_we     = 1'b1;
                    n_changed = 1'b1;
                end
                if (r_j + CNT_W'(1) == r_s) begin
                    if (r_map_ph) begin
                        n_state = ST_FL_B0;
                    end else begin
                        n_i     = CNT_W'(1);
                        n_r     = '0;
                        n_state = ST_BD_INIT;
                    end
                end else begin
                    n_j     = r_j + CNT_W'(1);
                    n_state = ST_RG_LO;
                end
            end

            // Move bounds by nearest-point comparison
            ST_BD_INIT: begin
                pt_raddr = '0;
                n_state  = ST_BD_P0;
            end
            ST_BD_P0: begin
                n_pa     = r_pt_rd;
                pt_raddr = SYM_W'(1);
                n_state  = ST_BD_P1;
            end
            ST_BD_P1: begin
                n_pb    = r_pt_rd;
                n_state = ST_BD_LOOP;
            end
            ST_BD_LOOP: begin
                if ((r_i + CNT_W'(1) < r_n) && (nr < r_s)) begin
                    dist_raddr = daddr(r_i[SYM_W-1:0], r_pa);
                    n_state    = ST_BD_RA;
                end else begin
                    n_state = ST_PASS_CHK;
                end
            end
            ST_BD_RA: begin
                n_here     = r_dist_rd;
                dist_raddr = daddr(r_i[SYM_W-1:0], r_pb);
                n_state    = ST_BD_RB;
            end
            ST_BD_RB: begin
                n_i = r_i + CNT_W'(1);
                if (r_dist_rd < r_here) begin
                    n_r       = nr;
                    bnd_we    = 1'b1;
                    bnd_waddr = nr;
                    bnd_wdata = r_i;
                    n_pa      = r_pb;
                    if (nr + CNT_W'(1) < r_s) begin
                        pt_raddr = 6'(nr + CNT_W'(1));
                        n_state  = ST_BD_P1;
                    end else begin
                        n_state = ST_BD_LOOP;
                    end
                end else begin
                    n_state = ST_BD_LOOP;
                end
            end

            // Clear the map, then walk regions once more to map and sum
            ST_MAP_CLR: begin
                map_we    = 1'b1;
                map_waddr = r_k[SYM_W-1:0];
                map_wdata = '0;
                if (r_k[SYM_W-1:0] == SYM_W'(MAX_STATES - 1)) begin
                    n_j           = '0;
                    n_map_ph      = 1'b1;
                    mac_ctl.clear = 1'b1;
                    n_state       = ST_RG_LO;
                end else begin
                    n_k = r_k + CNT_W'(1);
                end
            end

            // Copy the mapping of the first bound below it
            ST_FL_B0: begin
                bnd_raddr = '0;
                n_state   = ST_FL_B1;
            end
            ST_FL_B1: begin
                n_bndv    = r_bnd_rd;
                map_raddr = r_bnd_rd[SYM_W-1:0];
                n_state   = ST_FL_M;
            end
            ST_FL_M: begin
                n_fill  = r_map_rd;
                n_k     = '0;
                n_state = ST_FL_WR;
            end
            ST_FL_WR: begin
                if (r_k < r_bndv) begin
                    map_we    = 1'b1;
                    map_waddr = r_k[SYM_W-1:0];
                    map_wdata = r_fill;
                    n_k       = r_k + CNT_W'(1);
                end else begin
                    n_state = ST_FH_B;
                end
            end

            // Copy the mapping of bound S-1 at and above the last bound
            ST_FH_B: begin
                bnd_raddr = r_s;
                n_state   = ST_FH_BS;
            end
            ST_FH_BS: begin
                n_bndv    = r_bnd_rd;
                bnd_raddr = r_s - CNT_W'(1);
                n_state   = ST_FH_BP;
            end
            ST_FH_BP: begin
                map_raddr = r_bnd_rd[SYM_W-1:0];
                n_state   = ST_FH_M;
            end
            ST_FH_M: begin
                n_fill  = r_map_rd;
                n_k     = r_bndv;
                n_state = ST_FH_WR;
            end
            ST_FH_WR: begin
                if (r_k < r_n) begin
                    map_we    = 1'b1;
                    map_waddr = r_k[SYM_W-1:0];
                    map_wdata = r_fill;
                    n_k       = r_k + CNT_W'(1);
                end else begin
                    n_k     = '0;
                    n_state = ST_OUT_RD;
                end
            end

            // Emit one result per symbol
            ST_OUT_RD: begin
                n_state = ST_OUT_EM;
            end
            ST_OUT_EM: begin
                n_strobe               = 1'b1;
                n_out.source_symbol    = r_k[SYM_W-1:0];
                n_out.mapped_point     = r_map_rd[SYM_W] ? r_map_rd[SYM_W-1:0] : '0;
                n_out.last_of_run      = (r_k + CNT_W'(1) == r_n);
                n_out.total_distortion = mac_acc;
                n_out.passes_used      = r_pc;
                if (r_k + CNT_W'(1) == r_n) begin
                    n_state = ST_IDLE;
                end else begin
                    n_k     = r_k + CNT_W'(1);
                    n_state = ST_OUT_RD;
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_strobe  <= 1'b0;
            r_changed <= 1'b0;
            r_pc      <= '0;
            r_map_ph  <= 1'b0;
            r_first   <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_strobe  <= n_strobe;
            r_changed <= n_changed;
            r_pc      <= n_pc;
            r_map_ph  <= n_map_ph;
            r_first   <= n_first;
        end
    end

    // Working registers and result
    always_ff @(posedge i_clk) begin
        r_s      <= n_s;
        r_n      <= n_n;
        r_lim    <= n_lim;
        r_i      <= n_i;
        r_j      <= n_j;
        r_r      <= n_r;
        r_k      <= n_k;
        r_mc     <= n_mc;
        r_q      <= n_q;
        r_prev   <= n_prev;
        r_rem    <= n_rem;
        r_last   <= n_last;
        r_lo     <= n_lo;
        r_hi     <= n_hi;
        r_bndv   <= n_bndv;
        r_cur    <= n_cur;
        r_best   <= n_best;
        r_pa     <= n_pa;
        r_pb     <= n_pb;
        r_best_v <= n_best_v;
        r_here   <= n_here;
        r_fill   <= n_fill;
        r_out    <= n_out;
    end

endmodule

`default_nettype wire

// ===== hw/rtl/lmq_mac.sv =====
// ----------------------------------------------------------------------------
// lmq_mac
// Shared multiply-accumulate unit: registers the product of a probability
// and a distortion, then adds it into a saturating 38-bit accumulator.
// ----------------------------------------------------------------------------
`default_nettype none

module lmq_mac
    import lmq_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire t_mac_ctl            i_ctl,
    input  wire logic [WEIGHT_W-1:0] i_prob,
    input  wire logic [WEIGHT_W-1:0] i_dist,
    output logic      [SUM_W-1:0]    o_acc
);

    logic [2*WEIGHT_W-1:0] r_prod;
    logic [SUM_W-1:0]      r_acc;
    logic [SUM_W:0]        sum;

    assign sum   = {1'b0, r_acc} + (SUM_W+1)'(r_prod);
    assign o_acc = r_acc;

    // Register the product
    always_ff @(posedge i_clk) begin
        if (i_ctl.mul) begin
            r_prod <= i_prob * i_dist;
        end
    end

    // Accumulate, clamp at full scale
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
        end else if (i_ctl.clear) begin
            r_acc <= '0;
        end else if (i_ctl.acc) begin
            r_acc <= sum[SUM_W] ? {SUM_W{1'b1}} : sum[SUM_W-1:0];
        end
    end

endmodule

`default_nettype wire
